// ===== rtl/smi_pkg.sv =====
// Shared widths, fault codes and divider lane indexes for the inverse metric block.
package smi_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 24;
  localparam int N_IN   = 10;
  localparam int N_OUT  = 10;

  localparam int PROD_W = 2 * WORD_W;
  localparam int ADJ_W  = 2 * WORD_W + 1;
  localparam int DET_W  = 3 * WORD_W + 1;

  // Quotient bits kept per divider; larger quotients are flagged and clamped.
  localparam int QUO_W  = 2 * WORD_W + FRAC_W;

  localparam int NUM_A  = 2 * WORD_W + 2 * FRAC_W + 1;
  localparam int NUM_B  = 3 * WORD_W + 1;
  localparam int NUM_C  = 3 * FRAC_W + 2;
  localparam int NUM_AB = (NUM_A > NUM_B) ? NUM_A : NUM_B;
  localparam int NUM_W  = ((NUM_AB > NUM_C) ? NUM_AB : NUM_C) + 1;
  localparam int DEN_W  = 3 * WORD_W + 2;

  localparam int SQ_W   = QUO_W + 1;
  localparam int DIFF_W = QUO_W + 2;

  // Divider lanes: time-time, three time-space, six space-space, six outer terms.
  localparam int N_DIV  = 16;
  localparam int DV_TT  = 0;
  localparam int DV_TX  = 1;
  localparam int DV_SP  = 4;
  localparam int DV_OU  = 10;

  localparam int FLAG_W = 2;
  localparam logic [FLAG_W-1:0] FLT_OK   = 2'd0;
  localparam logic [FLAG_W-1:0] FLT_ZERO = 2'd1;
  localparam logic [FLAG_W-1:0] FLT_SAT  = 2'd2;
  localparam logic [FLAG_W-1:0] FLT_NONE = 2'd3;

endpackage

// ===== rtl/spacetime_metric_inverse_unit.sv =====
// Inverse four-metric of a 3+1 split: top level with multiplier front end and output stage.
// Pipeline: 5 multiply/sum stages, 89 divider stages (an input stage, then one quotient
// bit per stage), sign stage, output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat waits.
// Reset clears only the valid bits of the pipeline; data registers keep their contents.
module spacetime_metric_inverse_unit import smi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // lapse, shift_x, shift_y, shift_z, metric_xx, xy, xz, yy, yz, zz (32 bits each)
  input  logic [N_IN*WORD_W-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // inv_tt, inv_tx, inv_ty, inv_tz, inv_xx, xy, xz, yy, yz, zz (32 bits each)
  output logic [N_OUT*WORD_W-1:0] m_axis_tdata,
  // fault_flag
  output logic [FLAG_W-1:0]       m_axis_tuser
);

  localparam int NST = QUO_W + 8;
  localparam int DV0 = 5;

  typedef struct packed {
    logic             zero;
    logic [N_DIV-1:0] neg;
  } side_t;

  logic           ce;
  logic [NST-1:0] vld_q;

  assign ce            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Unpack input beat
  logic signed [WORD_W-1:0] alpha, beta [3], g [6];
  assign alpha = s_axis_tdata[0 +: WORD_W];
  for (genvar i = 0; i < 3; i++) begin : g_beta
    assign beta[i] = s_axis_tdata[(1+i)*WORD_W +: WORD_W];
  end
  for (genvar i = 0; i < 6; i++) begin : g_met
    assign g[i] = s_axis_tdata[(4+i)*WORD_W +: WORD_W];
  end

  // Stage 1: products
  logic signed [PROD_W-1:0] p1_q [12];
  logic signed [PROD_W-1:0] a2_1_q, bb1_q [6];
  logic signed [WORD_W-1:0] g1_q [3], b1_q [3];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      p1_q[0]  <= g[3] * g[5];
      p1_q[1]  <= g[4] * g[4];
      p1_q[2]  <= g[2] * g[4];
      p1_q[3]  <= g[1] * g[5];
      p1_q[4]  <= g[1] * g[4];
      p1_q[5]  <= g[2] * g[3];
      p1_q[6]  <= g[0] * g[5];
      p1_q[7]  <= g[2] * g[2];
      p1_q[8]  <= g[1] * g[2];
      p1_q[9]  <= g[0] * g[4];
      p1_q[10] <= g[0] * g[3];
      p1_q[11] <= g[1] * g[1];
      a2_1_q   <= alpha * alpha;
      bb1_q[0] <= beta[0] * beta[0];
      bb1_q[1] <= beta[0] * beta[1];
      bb1_q[2] <= beta[0] * beta[2];
      bb1_q[3] <= beta[1] * beta[1];
      bb1_q[4] <= beta[1] * beta[2];
      bb1_q[5] <= beta[2] * beta[2];
      for (int i = 0; i < 3; i++) begin
        g1_q[i] <= g[i];
        b1_q[i] <= beta[i];
      end
    end
  end

  // Stage 2: adjugate
  logic signed [ADJ_W-1:0]  adj2_q [6];
  logic signed [PROD_W-1:0] a2_2_q, bb2_q [6];
  logic signed [WORD_W-1:0] g2_q [3], b2_q [3];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < 6; k++) begin
        adj2_q[k] <= ADJ_W'(p1_q[2*k]) - ADJ_W'(p1_q[2*k+1]);
        bb2_q[k]  <= bb1_q[k];
      end
      a2_2_q <= a2_1_q;
      g2_q   <= g1_q;
      b2_q   <= b1_q;
    end
  end

  // Stage 3: determinant partial products, adjugate split into low and high halves
  logic signed [2*WORD_W:0] plo3_q [3], phi3_q [3];
  logic signed [ADJ_W-1:0]  adj3_q [6];
  logic signed [PROD_W-1:0] a2_3_q, bb3_q [6];
  logic signed [WORD_W-1:0] b3_q [3];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        plo3_q[k] <= g2_q[k] * $signed({1'b0, adj2_q[k][WORD_W-1:0]});
        phi3_q[k] <= g2_q[k] * $signed(adj2_q[k][ADJ_W-1:WORD_W]);
      end
      adj3_q <= adj2_q;
      bb3_q  <= bb2_q;
      a2_3_q <= a2_2_q;
      b3_q   <= b2_q;
    end
  end

  // Stage 4: determinant
  logic signed [DET_W-1:0]  det4_q;
  logic signed [ADJ_W-1:0]  adj4_q [6];
  logic signed [PROD_W-1:0] a2_4_q, bb4_q [6];
  logic signed [WORD_W-1:0] b4_q [3];
  logic signed [DET_W-1:0]  det_d;

  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + $signed({phi3_q[k], {WORD_W{1'b0}}}) + DET_W'(plo3_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      det4_q <= det_d;
      adj4_q <= adj3_q;
      bb4_q  <= bb3_q;
      a2_4_q <= a2_3_q;
      b4_q   <= b3_q;
    end
  end

  // Stage 5: rounding numerators (2|n| + |d|) and doubled denominators
  logic [NUM_W-1:0]  num5_q [N_DIV];
  logic [DEN_W-1:0]  den5_q [N_DIV];
  side_t             side5_q;
  logic [DET_W-1:0]  det_abs;
  logic [NUM_W-1:0]  a2_n;

  assign det_abs = det4_q[DET_W-1] ? DET_W'(-det4_q) : det4_q;
  assign a2_n    = NUM_W'(unsigned'(a2_4_q));

  always_ff @(posedge clk_i) begin
    if (ce) begin
      num5_q[DV_TT]    <= (NUM_W'(1) << (3*FRAC_W+1)) + a2_n;
      den5_q[DV_TT]    <= DEN_W'({a2_4_q, 1'b0});
      side5_q.neg[DV_TT] <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        // Magnitude of the most negative shift needs the full word unsigned
        num5_q[DV_TX+i] <= (NUM_W'(unsigned'(b4_q[i][WORD_W-1] ? WORD_W'(-b4_q[i])
                                                                 : b4_q[i]))
                            << (2*FRAC_W+1)) + a2_n;
        den5_q[DV_TX+i] <= DEN_W'({a2_4_q, 1'b0});
        side5_q.neg[DV_TX+i] <= b4_q[i][WORD_W-1];
      end
      for (int k = 0; k < 6; k++) begin
        num5_q[DV_SP+k] <= (NUM_W'(adj4_q[k][ADJ_W-1] ? ADJ_W'(-adj4_q[k]) : adj4_q[k])
                            << (2*FRAC_W+1)) + NUM_W'(det_abs);
        den5_q[DV_SP+k] <= DEN_W'({det_abs, 1'b0});
        side5_q.neg[DV_SP+k] <= adj4_q[k][ADJ_W-1] ^ det4_q[DET_W-1];
        num5_q[DV_OU+k] <= (NUM_W'(bb4_q[k][PROD_W-1] ? PROD_W'(-bb4_q[k]) : bb4_q[k])
                            << (FRAC_W+1)) + a2_n;
        den5_q[DV_OU+k] <= DEN_W'({a2_4_q, 1'b0});
        side5_q.neg[DV_OU+k] <= bb4_q[k][PROD_W-1];
      end
      side5_q.zero <= (a2_4_q == '0) || (det4_q == '0);
    end
  end

  // Divider lanes
  logic [QUO_W-1:0] quo [N_DIV];
  logic [N_DIV-1:0] ovf;

  for (genvar i = 0; i < N_DIV; i++) begin : g_div
    smi_div u_div (
      .clk_i (clk_i),
      .ce_i  (ce),
      .num_i (num5_q[i]),
      .den_i (den5_q[i]),
      .quo_o (quo[i]),
      .ovf_o (ovf[i])
    );
  end

  // Sideband delay matched to the divider
  side_t side_q [0:QUO_W];

  always_ff @(posedge clk_i) begin
    if (ce) begin
      side_q[0] <= side5_q;
      for (int k = 1; k <= QUO_W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Sign stage
  logic signed [SQ_W-1:0] sq_q [N_DIV];
  logic                   zero_f_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < N_DIV; i++) begin
        sq_q[i] <= side_q[QUO_W].neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      end
      zero_f_q <= side_q[QUO_W].zero;
    end
  end

  // Output stage: subtract, clamp, flag
  function automatic logic [WORD_W:0] sat_word(input logic signed [DIFF_W-1:0] x);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = DIFF_W'({1'b0, {(WORD_W-1){1'b1}}});
    lo = DIFF_W'($signed({1'b1, {(WORD_W-1){1'b0}}}));
    if (x > hi) begin
      sat_word = {1'b1, hi[WORD_W-1:0]};
    end else if (x < lo) begin
      sat_word = {1'b1, lo[WORD_W-1:0]};
    end else begin
      sat_word = {1'b0, x[WORD_W-1:0]};
    end
  endfunction

  logic [WORD_W:0]           res [N_OUT];
  logic [N_OUT-1:0]          clip;
  logic [N_OUT*WORD_W-1:0]   data_d;
  logic [N_OUT*WORD_W-1:0]   data_q;
  logic [FLAG_W-1:0]         flag_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = sat_word(DIFF_W'(sq_q[i]));
    end
    for (int k = 0; k < 6; k++) begin
      res[4+k] = sat_word(DIFF_W'(sq_q[DV_SP+k]) - DIFF_W'(sq_q[DV_OU+k]));
    end
    for (int i = 0; i < N_OUT; i++) begin
      clip[i]                    = res[i][WORD_W];
      data_d[i*WORD_W +: WORD_W] = res[i][WORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      if (zero_f_q) begin
        data_q <= '0;
        flag_q <= FLT_ZERO;
      end else begin
        data_q <= data_d;
        flag_q <= (|clip) ? FLT_SAT : FLT_OK;
      end
    end
  end

  assign m_axis_tdata = data_q;
  assign m_axis_tuser = flag_q;

`ifndef SYNTHESIS
  a_no_flag3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != FLT_NONE)
    else $error("reserved fault code on output");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == FLT_ZERO) |-> m_axis_tdata == '0)
    else $error("degenerate point with nonzero data");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipeline moved during output stall");

  a_outer_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DV0+QUO_W] && !side_q[QUO_W].zero) |-> ovf[DV_OU+5:DV_OU] == '0)
    else $error("outer term quotient overflow");

  a_tt_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DV0+QUO_W] && !side_q[QUO_W].zero) |-> !ovf[DV_TT])
    else $error("time-time quotient overflow");
`endif

endmodule

// ===== rtl/smi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module smi_div import smi_pkg::*; (
  input  logic             clk_i,
  input  logic             ce_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  logic [DEN_W-1:0] rem_q [0:QUO_W-1];
  logic [DEN_W-1:0] den_q [0:QUO_W-1];
  logic [QUO_W-1:0] sh_q  [0:QUO_W];
  logic             ovf_q [0:QUO_W];
  logic [NUM_W-1:0] hi;

  assign hi = num_i >> QUO_W;

  // Quotient too large for the kept bits when the top part already reaches the divisor.
  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0] <= hi[DEN_W-1:0];
      den_q[0] <= den_i;
      sh_q[0]  <= num_i[QUO_W-1:0];
      ovf_q[0] <= (hi >= NUM_W'(den_i));
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem_q[k-1], sh_q[k-1][QUO_W-1]};
    assign ge = (t >= {1'b0, den_q[k-1]});

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        sh_q[k]  <= {sh_q[k-1][QUO_W-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (ce_i) begin
          rem_q[k] <= ge ? DEN_W'(t - {1'b0, den_q[k-1]}) : t[DEN_W-1:0];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = ovf_q[QUO_W] ? {QUO_W{1'b1}} : sh_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the inverse four-metric unit.
`timescale 1ns / 100ps

class metric_inverse_board;
  typedef logic [smi_pkg::N_OUT*smi_pkg::WORD_W+smi_pkg::FLAG_W-1:0] point_t;
  point_t pending[$];
  int     fails;

  // Round n/d to nearest, ties away from zero; d nonzero.
  static function logic signed [255:0] div_round(logic signed [255:0] n,
                                                 logic signed [255:0] d);
    logic signed [255:0] an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  static function logic [31:0] clamp(logic signed [255:0] v, ref bit sat);
    if (v > 256'sd2147483647) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (v < -256'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function void note_point(logic [smi_pkg::N_IN*32-1:0] d);
    logic signed [255:0] a, b[3], g[6], adj[6], det, a2, sp, ou;
    logic [31:0] r[10];
    bit sat;
    int pi[6], pj[6];
    point_t p;
    pi = '{0, 0, 0, 1, 1, 2};
    pj = '{0, 1, 2, 1, 2, 2};
    sat = 0;
    a = $signed(d[31:0]);
    for (int k = 0; k < 3; k++) b[k] = $signed(d[32*(k+1) +: 32]);
    for (int k = 0; k < 6; k++) g[k] = $signed(d[32*(k+4) +: 32]);
    adj[0] = g[3]*g[5] - g[4]*g[4];
    adj[1] = g[2]*g[4] - g[1]*g[5];
    adj[2] = g[1]*g[4] - g[2]*g[3];
    adj[3] = g[0]*g[5] - g[2]*g[2];
    adj[4] = g[1]*g[2] - g[0]*g[4];
    adj[5] = g[0]*g[3] - g[1]*g[1];
    det = g[0]*adj[0] + g[1]*adj[1] + g[2]*adj[2];
    a2 = a * a;
    if (a2 == 0 || det == 0) begin
      p = {320'b0, smi_pkg::FLT_ZERO};
    end else begin
      r[0] = clamp(div_round(-(256'sd1 <<< 72), a2), sat);
      for (int k = 0; k < 3; k++) r[1+k] = clamp(div_round(b[k] <<< 48, a2), sat);
      for (int k = 0; k < 6; k++) begin
        sp = div_round(adj[k] <<< 48, det);
        ou = div_round((b[pi[k]] * b[pj[k]]) <<< 24, a2);
        r[4+k] = clamp(sp - ou, sat);
      end
      p[1:0] = sat ? smi_pkg::FLT_SAT : smi_pkg::FLT_OK;
      for (int k = 0; k < 10; k++) p[2+32*k +: 32] = r[k];
    end
    pending.push_back(p);
  endfunction

  function void check_point(logic [319:0] data, logic [1:0] flag);
    point_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat data=%h flag=%0d", $time, data, flag);
      fails++;
      return;
    end
    e = pending.pop_front();
    for (int k = 0; k < 10; k++)
      if (e[2+32*k +: 32] !== data[32*k +: 32]) begin
        $display("%0t: entry %0d expected %h actual %h", $time, k,
                 e[2+32*k +: 32], data[32*k +: 32]);
        fails++;
      end
    if (e[1:0] !== flag) begin
      $display("%0t: fault flag expected %0d actual %0d", $time, e[1:0], flag);
      fails++;
    end
  endfunction
endclass

module tb;
  import smi_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [N_IN*WORD_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [N_OUT*WORD_W-1:0] m_axis_tdata;
  logic [FLAG_W-1:0] m_axis_tuser;

  metric_inverse_board board = new();
  int cycles = 0;

  always #5 clk_i = ~clk_i;

  spacetime_metric_inverse_unit u_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("spacetime_metric_inverse_unit regression: fail");
      $finish;
    end
  end

  // Receiver stalls in bursts of its own rhythm.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_point(m_axis_tdata, m_axis_tuser);
    if ((cycles / 300) % 3 == 0) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'h01000000;
      4: return 32'hff000000;
      5: return $urandom_range(0, 32'h04000000) - 32'h02000000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-conditioned points: positive lapse and diagonal-dominant metric.
  function automatic logic [319:0] pick_point();
    logic [319:0] d;
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < 10; k++) d[32*k +: 32] = pick_word();
    end else begin
      d[31:0] = $urandom_range(32'h00100000, 32'h04000000);
      for (int k = 1; k < 4; k++) d[32*k +: 32] = $urandom_range(0, 32'h02000000) - 32'h01000000;
      for (int k = 4; k < 10; k++)
        d[32*k +: 32] = (k == 4 || k == 7 || k == 9) ? $urandom_range(32'h00800000, 32'h03000000)
                                                     : $urandom_range(0, 32'h00800000) - 32'h00400000;
      if ($urandom_range(0, 7) == 0) d[31:0] = -d[31:0];
    end
    return d;
  endfunction

  task automatic send_point(logic [319:0] d);
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(d);
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  initial begin
    logic [319:0] d;
    logic [31:0] one;
    one = 32'h01000000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: zero lapse, singular metric, extremes, saturation.
    send_point({one, 32'h0, 32'h0, one, 32'h0, one, 96'h0, one});
    send_point({one, 32'h0, 32'h0, one, 32'h0, one, 96'h0, 32'h0});
    send_point({one, 32'h0, 32'h0, 32'h0, 32'h0, one, 96'h0, one});
    send_point({one, one, one, one, one, one, 96'h0, one});
    send_point({one, 32'h0, 32'h0, one, 32'h0, one, 96'h0, 32'h00000001});
    send_point({one, 32'h0, 32'h0, one, 32'h0, one, 96'h0, 32'h80000000});
    send_point({one, 32'h0, 32'h0, one, 32'h0, one, {3{32'h7fffffff}}, 32'h7fffffff});
    send_point({{6{32'h7fffffff}}, {3{32'h80000000}}, 32'h80000000});
    send_point({{6{32'h80000000}}, {3{32'h7fffffff}}, 32'h7fffffff});
    send_point({32'h00000001, 32'h0, 32'h0, 32'h00000001, 32'h0, 32'h00000001, 96'h0, one});
    send_point({32'hffffffff, 32'h0, 32'h0, 32'h7fffffff, 32'h1, 32'h80000000,
                32'h55555555, 32'haaaaaaaa, 32'hffffffff, 32'hff000000});
    for (int k = 0; k < 10; k++) begin
      d = pick_point();
      send_point(d);
    end
    for (int k = 0; k < 800; k++) begin
      send_point(pick_point());
      if ((k / 100) % 2 == 1 && $urandom_range(0, 5) == 0) pause_sender();
    end
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.fails == 0) $display("spacetime_metric_inverse_unit regression: pass");
    else $display("spacetime_metric_inverse_unit regression: fail");
    $finish;
  end
endmodule
